@@ design/iqss_pkg.sv @@
`default_nettype none

package iqss_pkg;

  localparam int PORTS_DEF      = 8;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int STAMP_BITS_DEF = 16;

  localparam int PORT_W  = 3;
  localparam int FIELD_N = 8;
  localparam int DELAY_W = 16;
  localparam int ACT_W   = 4;
  localparam int LIM_W   = 5;
  localparam int CFG_W   = 5;

  localparam logic [ACT_W-1:0] ACT_RST = 4'd8;
  localparam logic [LIM_W-1:0] LIM_RST = 5'd4;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_ACTIVE_PORTS = 1'b0;
  localparam reg_idx_t REG_QUEUE_LIMIT  = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
  } grant_t;

  // v mod c for a 3-bit v and c in 1..8
  function automatic logic [PORT_W-1:0] mod_small(input logic [PORT_W-1:0] v,
                                                  input logic [PORT_W:0] c);
    logic [PORT_W:0] r;
    r = {1'b0, v};
    if (c <= 4'd1) begin
      r = '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (r >= c) begin
          r = r - c;
        end
      end
    end
    return r[PORT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/iqss_arbiter.sv @@
`default_nettype none

module iqss_arbiter #(
  parameter int PORTS = iqss_pkg::PORTS_DEF
) (
  input  wire logic [PORTS-1:0]            req,
  input  wire logic [iqss_pkg::PORT_W-1:0] pick_raw,
  output iqss_pkg::grant_t                 grant
);

  logic [iqss_pkg::PORT_W:0]   cnt;
  logic [iqss_pkg::PORT_W-1:0] k;
  logic [iqss_pkg::PORT_W:0]   seen;

  // pick the k-th requester in ascending port order
  always_comb begin
    cnt        = iqss_pkg::PORT_W'(0) + (iqss_pkg::PORT_W+1)'($countones(req));
    k          = iqss_pkg::mod_small(pick_raw, cnt);
    seen       = '0;
    grant      = '0;
    grant.hit  = |req;
    for (int p = 0; p < PORTS; p++) begin
      if (req[p]) begin
        if (seen == {1'b0, k}) begin
          grant.port = iqss_pkg::PORT_W'(p);
        end
        seen = seen + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/input_queued_switch_scheduler.sv @@
// Input-queued crossbar switch scheduler. One input transfer is one time slot: arrivals are
// appended to per-port FIFOs held in a single synchronous packet memory, then each active
// output picks one head-of-line contender by its random slice and reports the queueing delay.
// A slot walks the active ports through the memory (one arrival write and one head read per
// port), passes a drain state that covers the read latency, then steps the active outputs,
// one result transfer at most per cycle; output backpressure stalls the stepping. The packet
// memory needs no clearing pass.
`default_nettype none

module input_queued_switch_scheduler #(
  parameter int PORTS      = iqss_pkg::PORTS_DEF,
  parameter int FIFO_DEPTH = iqss_pkg::FIFO_DEPTH_DEF,
  parameter int STAMP_BITS = iqss_pkg::STAMP_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [iqss_pkg::FIELD_N-1:0]     in_arrival_valid,
  input  wire logic [3*iqss_pkg::FIELD_N-1:0]   in_arrival_dests,
  input  wire logic [3*iqss_pkg::FIELD_N-1:0]   in_random_bits,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_served,
  output logic [iqss_pkg::PORT_W-1:0]           out_output_port,
  output logic [iqss_pkg::PORT_W-1:0]           out_input_port,
  output logic [iqss_pkg::DELAY_W-1:0]          out_delay,
  output logic                                  out_last,
  input  wire logic                             cfg_we,
  input  wire iqss_pkg::reg_idx_t               cfg_index,
  input  wire logic [iqss_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int PW        = iqss_pkg::PORT_W;
  localparam int PIW       = $clog2(PORTS);
  localparam int CNTW      = $clog2(PORTS + 1);
  localparam int HW        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW        = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W     = (CW > iqss_pkg::LIM_W) ? CW : iqss_pkg::LIM_W;
  localparam int AW        = PIW + HW;
  localparam int MEM_DEPTH = PORTS * (2 ** HW);
  localparam int DW        = STAMP_BITS + PW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ARR   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_SCHED = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [iqss_pkg::ACT_W-1:0]   active_ports_r;
  logic [iqss_pkg::LIM_W-1:0]   queue_limit_r;
  logic [STAMP_BITS-1:0]        slot_r;
  logic [CNTW-1:0]              idx_r;
  logic                         any_r;

  logic [iqss_pkg::FIELD_N-1:0]   valid_r;
  logic [3*iqss_pkg::FIELD_N-1:0] dests_r;
  logic [3*iqss_pkg::FIELD_N-1:0] rnd_r;

  logic [HW-1:0]         head_r  [PORTS];
  logic [CW-1:0]         count_r [PORTS];
  logic [PORTS-1:0]      hv_r;
  logic [PW-1:0]         hd_r    [PORTS];
  logic [STAMP_BITS-1:0] hs_r    [PORTS];

  logic                  cap_v_r;
  logic [PIW-1:0]        cap_port_r;
  logic                  cap_fwd_r;
  logic                  cap_ne_r;
  logic [PW-1:0]         cap_dest_r;
  logic [STAMP_BITS-1:0] cap_stamp_r;

  logic [DW-1:0] mem [MEM_DEPTH];
  logic [DW-1:0] mem_q;

  logic                          out_valid_r;
  logic                          out_served_r;
  logic [PW-1:0]                 out_output_port_r;
  logic [PW-1:0]                 out_input_port_r;
  logic [iqss_pkg::DELAY_W-1:0]  out_delay_r;
  logic                          out_last_r;

  logic [iqss_pkg::ACT_W-1:0] n_eff;
  logic [CNTW-1:0]            n_c;
  logic [CMP_W-1:0]           lim;
  logic                       last_idx;
  logic [PIW-1:0]             cur_p;
  logic [PW-1:0]              p8;
  logic [PW-1:0]              dest_a [iqss_pkg::FIELD_N];
  logic [PW-1:0]              rnd_a  [iqss_pkg::FIELD_N];
  logic [PW-1:0]              arr_dest;
  logic                       arr_ok;
  logic [CW:0]                tail_sum;
  logic [CW:0]                tail_wrap;
  logic [HW-1:0]              tail_idx;
  logic [HW:0]                head_inc;
  logic [HW-1:0]              head_nxt;
  logic [PORTS-1:0]           req;
  logic                       later_any;
  iqss_pkg::grant_t           grant;
  logic [PIW-1:0]             win;
  logic                       in_xfer;
  logic                       out_free;
  logic                       sched_go;
  logic                       emit;

  always_comb begin
    if (active_ports_r == '0) begin
      n_eff = iqss_pkg::ACT_W'(1);
    end else if (active_ports_r > iqss_pkg::ACT_W'(PORTS)) begin
      n_eff = iqss_pkg::ACT_W'(PORTS);
    end else begin
      n_eff = active_ports_r;
    end
    if (CMP_W'(queue_limit_r) > CMP_W'(FIFO_DEPTH)) begin
      lim = CMP_W'(FIFO_DEPTH);
    end else begin
      lim = CMP_W'(queue_limit_r);
    end
  end

  assign n_c      = CNTW'(n_eff);
  assign last_idx = (idx_r == n_c - 1'b1);
  assign cur_p    = idx_r[PIW-1:0];
  assign p8       = PW'(idx_r);

  always_comb begin
    for (int i = 0; i < iqss_pkg::FIELD_N; i++) begin
      dest_a[i] = dests_r[3*i +: 3];
      rnd_a[i]  = rnd_r[3*i +: 3];
    end
  end

  // arrival for the port under the walk
  assign arr_dest  = dest_a[p8];
  assign arr_ok    = valid_r[p8] && ({1'b0, arr_dest} < n_eff) &&
                     (CMP_W'(count_r[cur_p]) < lim);
  assign tail_sum  = (CW+1)'(head_r[cur_p]) + (CW+1)'(count_r[cur_p]);
  assign tail_wrap = (tail_sum >= (CW+1)'(FIFO_DEPTH)) ?
                     tail_sum - (CW+1)'(FIFO_DEPTH) : tail_sum;
  assign tail_idx  = HW'(tail_wrap);

  always_ff @(posedge clk) begin
    if (state_r == ST_ARR && arr_ok) begin
      mem[{cur_p, tail_idx}] <= {slot_r, arr_dest};
    end
    mem_q <= mem[{cur_p, head_r[cur_p]}];
  end

  // contenders for the current output
  always_comb begin
    later_any = 1'b0;
    for (int p = 0; p < PORTS; p++) begin
      req[p] = hv_r[p] && (hd_r[p] == p8);
      if (hv_r[p] && (hd_r[p] > p8) && ({1'b0, hd_r[p]} < n_eff)) begin
        later_any = 1'b1;
      end
    end
  end

  iqss_arbiter #(
    .PORTS (PORTS)
  ) u_arb (
    .req      (req),
    .pick_raw (rnd_a[p8]),
    .grant    (grant)
  );

  assign win      = grant.port[PIW-1:0];
  assign head_inc = (HW+1)'(head_r[win]) + 1'b1;
  assign head_nxt = (head_inc == (HW+1)'(FIFO_DEPTH)) ? '0 : HW'(head_inc);

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign sched_go = (state_r == ST_SCHED) && out_free;
  assign emit     = sched_go && (grant.hit || (last_idx && !any_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ARR;
      end
      ST_ARR: begin
        if (last_idx) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_SCHED;
      end
      ST_SCHED: begin
        if (out_free && last_idx) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      active_ports_r <= iqss_pkg::ACT_RST;
      queue_limit_r  <= iqss_pkg::LIM_RST;
      slot_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE || state_r == ST_DRAIN) begin
        idx_r <= '0;
      end else if (state_r == ST_ARR || sched_go) begin
        idx_r <= last_idx ? '0 : idx_r + 1'b1;
      end
      if (sched_go && last_idx) begin
        slot_r <= slot_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          iqss_pkg::REG_ACTIVE_PORTS: active_ports_r <= cfg_wdata[iqss_pkg::ACT_W-1:0];
          iqss_pkg::REG_QUEUE_LIMIT:  queue_limit_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      valid_r <= in_arrival_valid;
      dests_r <= in_arrival_dests;
      rnd_r   <= in_random_bits;
    end
  end

  // fill counts and read pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PORTS; p++) begin
        head_r[p]  <= '0;
        count_r[p] <= '0;
      end
    end else if (state_r == ST_ARR && arr_ok) begin
      count_r[cur_p] <= count_r[cur_p] + 1'b1;
    end else if (sched_go && grant.hit) begin
      head_r[win]  <= head_nxt;
      count_r[win] <= count_r[win] - 1'b1;
    end
  end

  // head snapshot; an arrival into an empty FIFO is forwarded past the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_v_r <= 1'b0;
      hv_r    <= '0;
      any_r   <= 1'b0;
    end else begin
      cap_v_r <= (state_r == ST_ARR);
      if (in_xfer) begin
        hv_r  <= '0;
        any_r <= 1'b0;
      end else begin
        if (cap_v_r) hv_r[cap_port_r] <= cap_ne_r;
        if (sched_go && grant.hit) any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_port_r  <= cur_p;
    cap_fwd_r   <= (count_r[cur_p] == '0);
    cap_ne_r    <= (count_r[cur_p] != '0) || arr_ok;
    cap_dest_r  <= arr_dest;
    cap_stamp_r <= slot_r;
    if (cap_v_r) begin
      hd_r[cap_port_r] <= cap_fwd_r ? cap_dest_r  : mem_q[PW-1:0];
      hs_r[cap_port_r] <= cap_fwd_r ? cap_stamp_r : mem_q[DW-1:PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_served_r      <= grant.hit;
      out_output_port_r <= grant.hit ? p8 : '0;
      out_input_port_r  <= grant.hit ? grant.port : '0;
      out_delay_r       <= grant.hit ?
                           iqss_pkg::DELAY_W'(STAMP_BITS'(slot_r - hs_r[win])) : '0;
      out_last_r        <= grant.hit ? !later_any : 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_served      = out_served_r;
  assign out_output_port = out_output_port_r;
  assign out_input_port  = out_input_port_r;
  assign out_delay       = out_delay_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

@@ design/iqss_checker.sv @@
`default_nettype none

module iqss_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           out_served,
  input wire logic [iqss_pkg::PORT_W-1:0]    out_output_port,
  input wire logic [iqss_pkg::PORT_W-1:0]    out_input_port,
  input wire logic [iqss_pkg::DELAY_W-1:0]   out_delay,
  input wire logic                           out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_served) && $stable(out_delay) &&
      $stable(out_output_port) && $stable(out_input_port) && $stable(out_last))
    else $error("result changed while stalled");

  // one slot at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a slot is in progress");

  // a result that is not last belongs to a slot still in progress
  a_mid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("slot ended without a last result");

  // an empty slot report is all zero and closes the slot
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_served |-> out_last && out_delay == '0 &&
      out_output_port == '0 && out_input_port == '0)
    else $error("malformed empty slot result");

endmodule

bind input_queued_switch_scheduler iqss_checker u_iqss_checker (.*);

`default_nettype wire

@@ tb/sv/tb_input_queued_switch_scheduler.sv @@
module tb_input_queued_switch_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [iqss_pkg::FIELD_N-1:0]   arrivals;
    logic [3*iqss_pkg::FIELD_N-1:0] dests;
    logic [3*iqss_pkg::FIELD_N-1:0] picks;
  } slot_item_t;

  typedef struct packed {
    logic                         served;
    logic [iqss_pkg::PORT_W-1:0]  oport;
    logic [iqss_pkg::PORT_W-1:0]  iport;
    logic [iqss_pkg::DELAY_W-1:0] delay;
    logic                         last;
  } grant_rec_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [iqss_pkg::FIELD_N-1:0]   in_arrival_valid = '0;
  logic [3*iqss_pkg::FIELD_N-1:0] in_arrival_dests = '0;
  logic [3*iqss_pkg::FIELD_N-1:0] in_random_bits = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_served;
  logic [iqss_pkg::PORT_W-1:0]    out_output_port;
  logic [iqss_pkg::PORT_W-1:0]    out_input_port;
  logic [iqss_pkg::DELAY_W-1:0]   out_delay;
  logic                           out_last;
  logic                           cfg_we = 1'b0;
  iqss_pkg::reg_idx_t             cfg_index = iqss_pkg::REG_ACTIVE_PORTS;
  logic [iqss_pkg::CFG_W-1:0]     cfg_wdata = '0;

  input_queued_switch_scheduler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_arrival_valid(in_arrival_valid),
    .in_arrival_dests(in_arrival_dests),
    .in_random_bits  (in_random_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_served      (out_served),
    .out_output_port (out_output_port),
    .out_input_port  (out_input_port),
    .out_delay       (out_delay),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slot_item_t slots_q [$];
  grant_rec_t grant_q [$];

  // switch model state
  logic [iqss_pkg::ACT_W-1:0]   ports_cfg = iqss_pkg::ACT_RST;
  logic [iqss_pkg::LIM_W-1:0]   limit_cfg = iqss_pkg::LIM_RST;
  logic [iqss_pkg::DELAY_W-1:0] voq_stamp [iqss_pkg::PORTS_DEF][iqss_pkg::FIFO_DEPTH_DEF];
  logic [iqss_pkg::PORT_W-1:0]  voq_dest [iqss_pkg::PORTS_DEF][iqss_pkg::FIFO_DEPTH_DEF];
  int                           voq_rd [iqss_pkg::PORTS_DEF] = '{default: 0};
  int                           voq_fill [iqss_pkg::PORTS_DEF] = '{default: 0};
  logic [iqss_pkg::DELAY_W-1:0] cur_slot = '0;

  int         tx_hold = 0;
  int         rx_hold = 0;
  bit         quiet = 1'b0;
  int         mismatches = 0;
  slot_item_t nxt;
  grant_rec_t got;
  grant_rec_t want;
  bit         have;

  function automatic void put_slot(input slot_item_t it);
    slots_q = {slots_q, it};
  endfunction

  function automatic void put_grant(input grant_rec_t g);
    grant_q = {grant_q, g};
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly in-range destinations, some hotspot slots, some pure noise
  function automatic slot_item_t rand_slot(int n);
    slot_item_t it;
    int shape;
    int hot;
    shape = $urandom_range(0, 9);
    hot = $urandom_range(0, n - 1);
    it.arrivals = iqss_pkg::FIELD_N'($urandom);
    it.dests = (3*iqss_pkg::FIELD_N)'($urandom);
    it.picks = (3*iqss_pkg::FIELD_N)'($urandom);
    if (shape == 9) it.arrivals = '0;
    if (shape >= 2) begin
      for (int p = 0; p < iqss_pkg::PORTS_DEF; p++) begin
        it.dests[3*p +: 3] =
          iqss_pkg::PORT_W'((shape == 2) ? hot : $urandom_range(0, n - 1));
      end
    end
    return it;
  endfunction

  task automatic predict_slot(input slot_item_t it);
    int n;
    int lim;
    int cnt;
    int w;
    int made;
    int wr;
    int head_to [iqss_pkg::PORTS_DEF];
    int rivals [iqss_pkg::PORTS_DEF];
    logic [iqss_pkg::PORT_W-1:0] d;
    grant_rec_t res [iqss_pkg::PORTS_DEF];
    n = (ports_cfg == 0) ? 1 :
        ((ports_cfg > iqss_pkg::PORTS_DEF) ? iqss_pkg::PORTS_DEF : int'(ports_cfg));
    lim = (limit_cfg > iqss_pkg::FIFO_DEPTH_DEF) ? iqss_pkg::FIFO_DEPTH_DEF : int'(limit_cfg);
    for (int p = 0; p < n; p++) begin
      d = it.dests[3*p +: 3];
      if (it.arrivals[p] && d < n && voq_fill[p] < lim) begin
        wr = (voq_rd[p] + voq_fill[p]) % iqss_pkg::FIFO_DEPTH_DEF;
        voq_stamp[p][wr] = cur_slot;
        voq_dest[p][wr] = d;
        voq_fill[p]++;
      end
    end
    // heads are frozen before any pop
    for (int p = 0; p < iqss_pkg::PORTS_DEF; p++) begin
      head_to[p] = (p < n && voq_fill[p] > 0) ? int'(voq_dest[p][voq_rd[p]]) : -1;
    end
    made = 0;
    for (int o = 0; o < n; o++) begin
      cnt = 0;
      for (int p = 0; p < n; p++) begin
        if (head_to[p] == o) begin
          rivals[cnt] = p;
          cnt++;
        end
      end
      if (cnt > 0) begin
        w = rivals[int'(it.picks[3*o +: 3]) % cnt];
        res[made] = {1'b1, iqss_pkg::PORT_W'(o), iqss_pkg::PORT_W'(w),
                     iqss_pkg::DELAY_W'(cur_slot - voq_stamp[w][voq_rd[w]]), 1'b0};
        voq_rd[w] = (voq_rd[w] + 1) % iqss_pkg::FIFO_DEPTH_DEF;
        voq_fill[w]--;
        made++;
      end
    end
    if (made == 0) begin
      put_grant({1'b0, 3'd0, 3'd0, 16'd0, 1'b1});
    end else begin
      res[made-1].last = 1'b1;
      for (int i = 0; i < made; i++) put_grant(res[i]);
    end
    cur_slot++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_hold > 0) begin
        tx_hold = tx_hold - 1;
        in_valid <= 1'b0;
      end else if (slots_q.size() > 0) begin
        nxt = slots_q.pop_front();
        in_arrival_valid <= nxt.arrivals;
        in_arrival_dests <= nxt.dests;
        in_random_bits <= nxt.picks;
        in_valid <= 1'b1;
        tx_hold = quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_slot({in_arrival_valid, in_arrival_dests, in_random_bits});
    end
    if (rst_n && out_valid && out_ready) begin
      got = {out_served, out_output_port, out_input_port, out_delay, out_last};
      have = grant_q.size() != 0;
      if (have) want = grant_q.pop_front();
      if (!have || got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch%s: expected served=%0d out=%0d in=%0d %s%0d %s%0d",
                   $realtime, have ? "" : " (none expected)", want.served, want.oport,
                   want.iport, "delay=", want.delay, "last=", want.last);
          $display("%0t:   got served=%0d out=%0d in=%0d delay=%0d last=%0d", $realtime,
                   got.served, got.oport, got.iport, got.delay, got.last);
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) rx_hold = idle_len();
    end
  end

  task automatic drain();
    do @(negedge clk); while (slots_q.size() != 0 || in_valid || grant_q.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic cfg_write(input iqss_pkg::reg_idx_t idx,
                           input logic [iqss_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == iqss_pkg::REG_ACTIVE_PORTS) ports_cfg = val[iqss_pkg::ACT_W-1:0];
    else limit_cfg = val[iqss_pkg::LIM_W-1:0];
  endtask

  task automatic run_phase(input logic [iqss_pkg::ACT_W-1:0] ports,
                           input logic [iqss_pkg::LIM_W-1:0] lim,
                           input int count, input bit calm);
    int n;
    drain();
    cfg_write(iqss_pkg::REG_ACTIVE_PORTS, iqss_pkg::CFG_W'(ports));
    cfg_write(iqss_pkg::REG_QUEUE_LIMIT, iqss_pkg::CFG_W'(lim));
    @(negedge clk);
    quiet = calm;
    n = (ports == 0) ? 1 :
        ((ports > iqss_pkg::PORTS_DEF) ? iqss_pkg::PORTS_DEF : int'(ports));
    repeat (count) put_slot(rand_slot(n));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset config: 8 ports, limit 4
    put_slot({8'h00, 24'h000000, 24'h000000});
    put_slot({8'hFF, 24'h000000, 24'h000000});
    put_slot({8'hFF, 24'h000000, 24'hFFFFFF});
    put_slot({8'hFF, 24'hFAC688, 24'hFFFFFF});
    put_slot({8'hFF, 24'h053977, 24'h000000});
    put_slot({8'hFF, 24'hFFFFFF, 24'h000000});
    put_slot({8'hFF, 24'hFFFFFF, 24'hFFFFFF});
    put_slot({8'hFF, 24'hFFFFFF, 24'h924924});
    put_slot({8'hFF, 24'hFFFFFF, 24'h492492});
    put_slot({8'hFF, 24'hFFFFFF, 24'hB6DB6D});
    put_slot({8'h55, 24'hFFFFFF, 24'hAAAAAA});
    put_slot({8'hAA, 24'h000000, 24'h555555});
    put_slot({8'h01, 24'h000007, 24'h000000});
    put_slot({8'h80, 24'hE00000, 24'hE00000});
    put_slot({8'h00, 24'hFFFFFF, 24'hFFFFFF});
    put_slot({8'h00, 24'h000000, 24'h249249});
    run_phase(4'd8, 5'd16, 20, 1'b0);
    run_phase(4'd3, 5'd2, 20, 1'b0);
    // limit lowered below the current fill
    run_phase(4'd3, 5'd1, 12, 1'b0);
    run_phase(4'd1, 5'd1, 12, 1'b1);
    run_phase(4'd0, 5'd0, 10, 1'b0);
    run_phase(4'd15, 5'd31, 15, 1'b0);
    run_phase(4'd6, 5'd8, 15, 1'b0);
    run_phase(4'd8, 5'd0, 20, 1'b0);
    // park a packet for output 5 at port 0, then shrink to one port so it
    // stays blocked while port 0 fills behind it
    run_phase(4'd8, 5'd16, 0, 1'b0);
    put_slot({8'h03, 24'h00002D, 24'h008000});
    run_phase(4'd1, 5'd16, 8, 1'b1);
    run_phase(4'd8, 5'd4, 10, 1'b0);
    drain();
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("input_queued_switch_scheduler verification clean");
    end else begin
      $display("input_queued_switch_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("input_queued_switch_scheduler verification failed");
    $finish;
  end

endmodule
